>>> rtl/txcw_pkg.sv
// Shared constants, types and state codes for the text console writer.
package txcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int LAST_CELL = CELL_COUNT - 1;
	localparam int BOTTOM_ROW_START = CELL_COUNT - COLUMNS;
	localparam int QUEUE_DEPTH = 2;

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Fixed field widths of the result transfer
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_COL_W = 7;
	localparam int OUT_IDX_W = 11;
	localparam int CELL_W = 16;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;
	localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h09;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] cursor_row;
		logic [OUT_COL_W-1:0] cursor_column;
		logic [OUT_IDX_W-1:0] cell_index;
		logic [CELL_W-1:0]    cell_value;
		logic                 wrote_cell;
		logic                 scrolled;
		logic                 line_ended;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ATTR_W-1:0] attr;
		result_t           res;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic scrolling;
	} back_status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_FILL
	} back_state_t;

endpackage

>>> rtl/txcw_front.sv
// Front end: cursor tracking, attribute register and command build.
module txcw_front import txcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	output cmd_t              cmd
);

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;

	logic              is_nl;
	logic              at_row_end;
	logic              at_last_row;
	logic              row_adv;
	logic              scroll;
	logic [ROW_W-1:0]  row_n;
	logic [COL_W-1:0]  col_n;
	logic [ADDR_W-1:0] cell_addr;

	always_comb begin
		is_nl       = (char_code == NEWLINE_CODE);
		at_row_end  = (col_q == COL_W'(COLUMNS - 1));
		at_last_row = (row_q == ROW_W'(ROWS - 1));
		row_adv     = is_nl || at_row_end;
		scroll      = row_adv && at_last_row;
		col_n       = row_adv ? '0 : col_q + COL_W'(1);
		row_n       = (row_adv && !at_last_row) ? row_q + ROW_W'(1) : row_q;
		cell_addr   = ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q);
	end

	always_comb begin
		cmd.addr              = cell_addr;
		cmd.attr              = attr_q;
		cmd.res.cursor_row    = OUT_ROW_W'(row_n);
		cmd.res.cursor_column = OUT_COL_W'(col_n);
		cmd.res.cell_index    = is_nl ? '0 : OUT_IDX_W'(cell_addr);
		cmd.res.cell_value    = is_nl ? '0 : {attr_q, char_code};
		cmd.res.wrote_cell    = !is_nl;
		cmd.res.scrolled      = scroll;
		cmd.res.line_ended    = is_nl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			attr_q <= RESET_ATTRIBUTE;
		end else begin
			if (accept) begin
				row_q <= row_n;
				col_q <= col_n;
			end
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
		end
	end

endmodule

>>> rtl/txcw_fifo.sv
// Short command queue between the front end and the screen engine.
module txcw_fifo import txcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic full,
	output logic empty
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/txcw_back.sv
// Screen engine: cell memory, clear sweep, scroll copy and fill, result register.
module txcw_back import txcw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  logic         q_empty,
	output logic         pop,
	input  logic         out_stall,
	output logic         out_valid,
	output result_t      result,
	output back_status_t status
);

	logic [CELL_W-1:0] mem [CELL_COUNT];

	back_state_t       state_q;
	back_state_t       state_n;
	logic [ADDR_W-1:0] cnt_q;
	logic [ATTR_W-1:0] fill_attr_q;
	logic              out_valid_q;
	result_t           result_q;

	// Copy pipeline: read issued at cnt_q, written in the following cycle a row up
	logic              pend_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic [CELL_W-1:0] rd_data_s1;

	logic              take;
	logic              cnt_last;
	logic              fill_we;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [CELL_W-1:0] mem_wd;

	assign cnt_last  = (cnt_q == ADDR_W'(LAST_CELL));
	assign take      = (state_q == ST_IDLE) && !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_last) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				if (take && cmd.res.scrolled) state_n = ST_COPY;
			end
			ST_COPY: begin
				if (cnt_last) state_n = ST_FILL;
			end
			ST_FILL: begin
				if (fill_we && cnt_last) state_n = ST_IDLE;
			end
			default: state_n = ST_CLEAR;
		endcase
	end

	always_comb begin
		pop              = 1'b0;
		fill_we          = 1'b0;
		mem_we           = 1'b0;
		mem_wa           = cnt_q;
		mem_wd           = {RESET_ATTRIBUTE, BLANK_CHAR};
		status.clearing  = 1'b0;
		status.scrolling = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				status.clearing = 1'b1;
				mem_we          = 1'b1;
			end
			ST_IDLE: begin
				pop    = take;
				mem_we = take && cmd.res.wrote_cell;
				mem_wa = cmd.addr;
				mem_wd = cmd.res.cell_value;
			end
			ST_COPY: begin
				status.scrolling = 1'b1;
				mem_we           = pend_s1;
				mem_wa           = dst_s1;
				mem_wd           = rd_data_s1;
			end
			ST_FILL: begin
				status.scrolling = 1'b1;
				// finish the last copied cell before the blank row starts
				if (pend_s1) begin
					mem_we = 1'b1;
					mem_wa = dst_s1;
					mem_wd = rd_data_s1;
				end else begin
					fill_we = 1'b1;
					mem_we  = 1'b1;
					mem_wd  = {fill_attr_q, BLANK_CHAR};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		dst_s1 <= cnt_q - ADDR_W'(COLUMNS);
		if (take) begin
			result_q <= cmd.res;
		end
		if (take && cmd.res.scrolled) begin
			fill_attr_q <= cmd.attr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			pend_s1 <= (state_q == ST_COPY);
			case (state_q)
				ST_CLEAR: cnt_q <= cnt_last ? '0 : cnt_q + ADDR_W'(1);
				ST_IDLE: begin
					if (take && cmd.res.scrolled) cnt_q <= ADDR_W'(COLUMNS);
				end
				ST_COPY: cnt_q <= cnt_last ? ADDR_W'(BOTTOM_ROW_START) : cnt_q + ADDR_W'(1);
				ST_FILL: begin
					if (fill_we) cnt_q <= cnt_last ? '0 : cnt_q + ADDR_W'(1);
				end
				default: cnt_q <= '0;
			endcase
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/text_console_writer_top.sv
// Top level of the text console writer: front end, command queue, screen engine.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall    char_code
//   cfg       input      cfg_we                 cfg_wdata (text attribute)
//   out       output     out_valid / out_stall  cursor_row, cursor_column, cell_index,
//                                               cell_value, wrote_cell, scrolled, line_ended
//
// A character taken at the input is pushed into the command queue; the screen engine moves it into
// the output register, from which it transfers while out_stall is low. Plain characters and
// newlines sustain one per cycle while neither the output nor a scroll stalls.
// A scroll holds the screen engine while it copies one cell per cycle through the memory's
// read port, then fills the bottom row; the two-entry queue absorbs the next two characters,
// then input stalls. After reset the engine clears all CELL_COUNT cells, one per cycle, and
// input stalls meanwhile; configuration writes are taken at any time.
module text_console_writer_top import txcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic                 cfg_we,
	input  logic [ATTR_W-1:0]    cfg_wdata,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_ROW_W-1:0] cursor_row,
	output logic [OUT_COL_W-1:0] cursor_column,
	output logic [OUT_IDX_W-1:0] cell_index,
	output logic [CELL_W-1:0]    cell_value,
	output logic                 wrote_cell,
	output logic                 scrolled,
	output logic                 line_ended
);

	cmd_t         front_cmd;
	cmd_t         queue_cmd;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;
	logic         accept;
	back_status_t status;
	result_t      result;

	assign in_stall = q_full || status.clearing;
	assign accept   = in_valid && !in_stall;

	txcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (front_cmd)
	);

	txcw_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (front_cmd),
		.pop    (q_pop),
		.dout   (queue_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	txcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queue_cmd),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result),
		.status    (status)
	);

	assign cursor_row    = result.cursor_row;
	assign cursor_column = result.cursor_column;
	assign cell_index    = result.cell_index;
	assign cell_value    = result.cell_value;
	assign wrote_cell    = result.wrote_cell;
	assign scrolled      = result.scrolled;
	assign line_ended    = result.line_ended;

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (cursor_row == OUT_ROW_W'(ROWS - 1)))
		else $error("scroll reported off the last row");

	a_newline_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_ended) |-> (!wrote_cell && cursor_column == '0 && cell_value == '0))
		else $error("newline result carries a cell write");

	a_no_pop_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		(status.scrolling || status.clearing) |-> !q_pop)
		else $error("command taken while the screen engine is busy");
`endif

endmodule

>>> verif/tb_text_console_writer_top.sv
// Self-checking testbench for the text console writer: table-driven and random text.
`timescale 1ns / 1ps

module tb_text_console_writer_top;
	import txcw_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_ITEMS = 250;
	localparam int PHASE_COUNT = 5;

	typedef enum logic {ROW_CHAR, ROW_ATTR} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [CHAR_W-1:0]  data;
		int                 reps;
		bit                 typed;
		result_t            want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CHAR_W-1:0]    char_code;
	logic                 cfg_we;
	logic [ATTR_W-1:0]    cfg_wdata;
	logic                 out_valid;
	logic                 out_stall;
	logic [OUT_ROW_W-1:0] cursor_row;
	logic [OUT_COL_W-1:0] cursor_column;
	logic [OUT_IDX_W-1:0] cell_index;
	logic [CELL_W-1:0]    cell_value;
	logic                 wrote_cell;
	logic                 scrolled;
	logic                 line_ended;

	// shadow of the console state
	logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
	int                shadow_row;
	int                shadow_col;
	logic [ATTR_W-1:0] shadow_attr;

	result_t   pending_results [$];
	stim_row_t stim_table [$];

	bit idle_enable;
	int mismatches;
	int results_checked;
	int chars_sent;
	int newlines_sent;
	int row_wraps;
	int scroll_count;
	int attr_writes;
	int quiet_cycles;

	text_console_writer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column),
		.cell_index    (cell_index),
		.cell_value    (cell_value),
		.wrote_cell    (wrote_cell),
		.scrolled      (scrolled),
		.line_ended    (line_ended)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Advance the cursor for one character and return the result it reports.
	function automatic result_t console_step(input logic [CHAR_W-1:0] code);
		result_t r;
		bit      next_line;
		int      i;
		r = '0;
		next_line = 1'b0;
		if (code == NEWLINE_CODE) begin
			shadow_col = 0;
			r.line_ended = 1'b1;
			next_line = 1'b1;
		end else begin
			r.cell_index = OUT_IDX_W'(shadow_row * COLUMNS + shadow_col);
			r.cell_value = {shadow_attr, code};
			r.wrote_cell = 1'b1;
			shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, code};
			if (shadow_col == COLUMNS - 1) begin
				shadow_col = 0;
				next_line = 1'b1;
			end else begin
				shadow_col++;
			end
		end
		if (next_line) begin
			if (shadow_row == ROWS - 1) begin
				for (i = 0; i < BOTTOM_ROW_START; i++)
					shadow_screen[i] = shadow_screen[i + COLUMNS];
				for (i = BOTTOM_ROW_START; i < CELL_COUNT; i++)
					shadow_screen[i] = {shadow_attr, BLANK_CHAR};
				r.scrolled = 1'b1;
			end else begin
				shadow_row++;
			end
		end
		r.cursor_row = OUT_ROW_W'(shadow_row);
		r.cursor_column = OUT_COL_W'(shadow_col);
		return r;
	endfunction

	task automatic add_row(input row_kind_t kind, input logic [CHAR_W-1:0] data,
			input int reps, input bit typed = 1'b0, input int r = 0, input int c = 0,
			input int idx = 0, input int val = 0, input bit wr = 1'b0,
			input bit sc = 1'b0, input bit le = 1'b0);
		stim_row_t row;
		row.kind = kind;
		row.data = data;
		row.reps = reps;
		row.typed = typed;
		row.want.cursor_row = OUT_ROW_W'(r);
		row.want.cursor_column = OUT_COL_W'(c);
		row.want.cell_index = OUT_IDX_W'(idx);
		row.want.cell_value = CELL_W'(val);
		row.want.wrote_cell = wr;
		row.want.scrolled = sc;
		row.want.line_ended = le;
		stim_table.push_back(row);
	endtask

	// Call at a falling edge; leaves valid high so back-to-back transfers run at full rate.
	task automatic push_char(input logic [CHAR_W-1:0] code, input bit use_typed,
			input result_t typed);
		result_t predicted;
		if (idle_enable && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid = 1'b1;
		char_code = code;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = console_step(code);
		pending_results.push_back(use_typed ? typed : predicted);
		if (predicted.line_ended)
			newlines_sent++;
		else
			chars_sent++;
		if (predicted.wrote_cell && predicted.cursor_column == 0)
			row_wraps++;
		if (predicted.scrolled)
			scroll_count++;
		@(negedge clk);
	endtask

	// Call at a falling edge. Hold input until every result is back, then write.
	task automatic set_attribute(input logic [ATTR_W-1:0] value);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		// let a scroll that trails its own result finish
		repeat (CELL_COUNT + 16) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		shadow_attr = value;
		attr_writes++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result transfer with none expected, actual row %0d col %0d",
					$time, cursor_row, cursor_column);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("cursor_row", 32'(want.cursor_row), 32'(cursor_row));
				compare_field("cursor_column", 32'(want.cursor_column), 32'(cursor_column));
				compare_field("cell_index", 32'(want.cell_index), 32'(cell_index));
				compare_field("cell_value", 32'(want.cell_value), 32'(cell_value));
				compare_field("wrote_cell", 32'(want.wrote_cell), 32'(wrote_cell));
				compare_field("scrolled", 32'(want.scrolled), 32'(scrolled));
				compare_field("line_ended", 32'(want.line_ended), 32'(line_ended));
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no transfer for %0d cycles at %0t ns", WATCHDOG_LIMIT, $time);
		$display("end of test: mismatches");
		$finish;
	end

	// result side stalls in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 9) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin : stimulus
		logic [ATTR_W-1:0] phase_attr [PHASE_COUNT];
		int                k;
		int                p;
		int                n;
		int                pick;
		int                len;
		int                phase_count;

		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_enable = 1'b1;
		chars_sent = 0;
		newlines_sent = 0;
		row_wraps = 0;
		scroll_count = 0;
		attr_writes = 0;
		shadow_row = 0;
		shadow_col = 0;
		shadow_attr = RESET_ATTRIBUTE;
		for (k = 0; k < CELL_COUNT; k++)
			shadow_screen[k] = {RESET_ATTRIBUTE, BLANK_CHAR};

		// kind, code, count, typed, row, col, index, value, wrote, scrolled, line end
		add_row(ROW_CHAR, 8'h41, 1, 1, 0, 1, 0, 'h0941, 1, 0, 0);
		add_row(ROW_CHAR, NEWLINE_CODE, 1, 1, 1, 0, 0, 0, 0, 0, 1);
		add_row(ROW_CHAR, 8'h00, 1, 1, 1, 1, 80, 'h0900, 1, 0, 0);
		add_row(ROW_CHAR, 8'hFF, 1, 1, 1, 2, 81, 'h09FF, 1, 0, 0);
		add_row(ROW_CHAR, NEWLINE_CODE, 1, 1, 2, 0, 0, 0, 0, 0, 1);
		add_row(ROW_CHAR, NEWLINE_CODE, 1, 1, 3, 0, 0, 0, 0, 0, 1);
		add_row(ROW_CHAR, 8'h0B, 1, 1, 3, 1, 240, 'h090B, 1, 0, 0);
		add_row(ROW_CHAR, 8'h09, 1, 1, 3, 2, 241, 'h0909, 1, 0, 0);
		add_row(ROW_CHAR, 8'h78, COLUMNS - 2);                   // fill the row, wrap
		add_row(ROW_CHAR, NEWLINE_CODE, ROWS - 6);
		add_row(ROW_CHAR, NEWLINE_CODE, 1, 1, 24, 0, 0, 0, 0, 0, 1);
		add_row(ROW_CHAR, NEWLINE_CODE, 1, 1, 24, 0, 0, 0, 0, 1, 1); // scroll on newline
		add_row(ROW_CHAR, 8'h7A, COLUMNS - 1);
		add_row(ROW_CHAR, 8'h7E, 1, 1, 24, 0, 1999, 'h097E, 1, 1, 0); // write, then scroll
		add_row(ROW_CHAR, 8'h80, 1, 1, 24, 1, 1920, 'h0980, 1, 0, 0);
		add_row(ROW_ATTR, 8'hFF, 0);
		add_row(ROW_CHAR, 8'hFF, 1, 1, 24, 2, 1921, 'hFFFF, 1, 0, 0);
		add_row(ROW_CHAR, 8'h00, 1, 1, 24, 3, 1922, 'hFF00, 1, 0, 0);
		add_row(ROW_CHAR, NEWLINE_CODE, 1, 1, 24, 0, 0, 0, 0, 1, 1);
		add_row(ROW_ATTR, 8'h00, 0);
		add_row(ROW_CHAR, 8'h01, 1, 1, 24, 1, 1920, 'h0001, 1, 0, 0);
		add_row(ROW_CHAR, NEWLINE_CODE, 1, 1, 24, 0, 0, 0, 0, 1, 1);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < stim_table.size(); k++) begin
			if (stim_table[k].kind == ROW_ATTR) begin
				set_attribute(stim_table[k].data);
			end else begin
				repeat (stim_table[k].reps)
					push_char(stim_table[k].data, stim_table[k].typed, stim_table[k].want);
			end
		end

		phase_attr[0] = ATTR_W'($urandom_range(0, 255));
		phase_attr[1] = 8'hFF;
		phase_attr[2] = ATTR_W'($urandom_range(0, 255));
		phase_attr[3] = 8'h00;
		phase_attr[4] = RESET_ATTRIBUTE;

		for (p = 0; p < PHASE_COUNT; p++) begin
			set_attribute(phase_attr[p]);
			// last phase runs at full rate on both sides
			idle_enable = (p != PHASE_COUNT - 1);
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				pick = $urandom_range(0, 19);
				if (pick < 11)
					len = $urandom_range(0, 20);
				else if (pick < 15)
					len = $urandom_range(60, 100);
				else if (pick < 17)
					len = $urandom_range(150, 250);
				else if (pick == 17)
					len = COLUMNS - 1;
				else if (pick == 18)
					len = COLUMNS;
				else
					len = 0;
				for (n = 0; n < len; n++)
					push_char(CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
				phase_count += len;
				// most lines end in a newline, some run on into the next
				if ($urandom_range(0, 9) != 0) begin
					push_char(NEWLINE_CODE, 1'b0, '0);
					phase_count++;
				end
			end
		end

		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("coverage: %0d characters, %0d newlines, %0d row wraps, %0d scrolls",
			chars_sent, newlines_sent, row_wraps, scroll_count);
		$display("coverage: %0d attribute writes, %0d results checked, %0d mismatches",
			attr_writes, results_checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
